@@ hw/rtl/ebj_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebj_pkg: shared types and constants of the backoff delay generator
// Widths, register indexes, input kinds, controller states and datapath
// command bundle.
// ----------------------------------------------------------------------------
package ebj_pkg;

    // Fixed-point layout of the running delay
    localparam int FRAC_BITS   = 16;          // fraction bits of the running delay
    localparam int RUN_W       = 48;          // running delay width
    localparam int DELAY_W     = 32;          // millisecond fields
    localparam int ATTEMPT_W   = 32;
    localparam int GROWTH_W    = 16;          // Q8.8 growth factor
    localparam int GROWTH_FRAC = 8;
    localparam int RATIO_W     = 17;          // Q0.16 spread ratio, 1.0 included
    localparam int SAMPLE_W    = 16;          // Q1.15 sample
    localparam int WIDE_W      = RUN_W + GROWTH_W;
    localparam int RM_W        = 32;          // ratio * |sample|, at most 2^31
    localparam int JIT_W       = DELAY_W + RM_W;
    localparam int JIT_FRAC    = 31;
    localparam int SUM_W       = JIT_W + 1;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 3 * DELAY_W;

    // Register indexes of the configuration port
    localparam logic [CFG_INDEX_W-1:0] REG_INITIAL = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_MAXIMUM = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_GROWTH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SPREAD  = 2'd3;

    // Reset values of the registers
    localparam logic [DELAY_W-1:0]  INITIAL_RESET = 32'd1000;
    localparam logic [DELAY_W-1:0]  MAXIMUM_RESET = 32'd60000;
    localparam logic [GROWTH_W-1:0] GROWTH_RESET  = 16'd512;
    localparam logic [RATIO_W-1:0]  SPREAD_RESET  = 17'd0;
    localparam logic [RATIO_W-1:0]  RATIO_ONE     = 17'h10000;

    // Input kinds
    localparam logic KIND_NEXT  = 1'b0;
    localparam logic KIND_RESET = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_GROW,
        ST_NOM,
        ST_JIT,
        ST_SUM,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic capture;   // latch sample of a next beat
        logic clear;     // reset beat: clear counter and running delay
        logic grow;      // advance counter and running delay
        logic nom;       // cap nominal delay
        logic jit;       // form jitter magnitude
        logic sum;       // apply jitter to nominal
        logic load_out;  // round, clamp and load result register
    } dp_cmd_t;

endpackage

@@ hw/rtl/exponential_backoff_jitter_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_backoff_jitter_unit: retry delay generator with jitter
// Next beat: bump the saturating attempt counter, advance the running
// 32.16 delay product, report nominal and jittered delay. Reset beat:
// clear counter and product, no result.
// ----------------------------------------------------------------------------
//
//  channel | direction | tdata (low bit up)                         | tuser
//  --------+-----------+--------------------------------------------+------
//  s_      | in        | random_sample[15:0]                         | kind
//  m_      | out       | attempt_number, nominal_ms, jittered_ms     | -
//  cfg_    | in        | index 0 initial, 1 maximum, 2 growth, 3 spread
//
//  A next beat walks these steps in order: acceptance, then growth
//  multiply, nominal cap, nominal x window multiply, jitter sum, and
//  round/clamp into the result register. The chained multipliers (48x16,
//  17x16, 32x32) are each registered. A reset beat is taken in the idle
//  state and starts no chain. Synchronous active-low reset restores
//  register defaults and clears counter and product. The final step stalls
//  while the result register is full and m_tready is low; s_tready is held
//  low until the chain finishes, so such a stall also holds off the next beat.
//
module exponential_backoff_jitter_unit (
    input  logic                            aclk,
    input  logic                            aresetn,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [ebj_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ebj_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    // request stream
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ebj_pkg::IN_DATA_W-1:0]   s_tdata,   // [15:0] random_sample
    input  logic                            s_tuser,   // [0] kind
    // result stream
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ebj_pkg::OUT_DATA_W-1:0]  m_tdata    // [31:0] attempt_number,
                                                       // [63:32] nominal_ms,
                                                       // [95:64] jittered_ms
);
    import ebj_pkg::*;

    dp_cmd_t cmd;

    // Sequencer: one beat in flight, owns both handshakes
    ebj_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    // Arithmetic, state and configuration
    ebj_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .sample    (s_tdata[SAMPLE_W-1:0]),
        .result    (m_tdata)
    );

endmodule

@@ hw/rtl/ebj_datapath.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebj_datapath: registers and arithmetic of the backoff delay generator
// Holds configuration, attempt counter, running delay and the jitter chain;
// each step is enabled by one command from the controller.
// ----------------------------------------------------------------------------
module ebj_datapath (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [ebj_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ebj_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  ebj_pkg::dp_cmd_t                cmd,
    input  logic [ebj_pkg::SAMPLE_W-1:0]    sample,
    output logic [ebj_pkg::OUT_DATA_W-1:0]  result
);
    import ebj_pkg::*;

    function automatic logic [RUN_W-1:0] sat_run(input logic [WIDE_W-1:0] v);
        return (|v[WIDE_W-1:RUN_W]) ? {RUN_W{1'b1}} : v[RUN_W-1:0];
    endfunction

    logic [DELAY_W-1:0]   initial_reg;
    logic [DELAY_W-1:0]   maximum_reg;
    logic [GROWTH_W-1:0]  growth_reg;
    logic [RATIO_W-1:0]   spread_reg;
    logic [ATTEMPT_W-1:0] attempt_reg, attempt_next;
    logic [RUN_W-1:0]     run_reg, run_next;
    logic                 neg_reg;
    logic [SAMPLE_W-1:0]  mag_reg, mag_next;
    logic [RM_W-1:0]      rm_reg;
    logic [DELAY_W-1:0]   nominal_reg, nominal_next;
    logic [JIT_W-1:0]     jit_reg, jit_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [DELAY_W-1:0]   att_out_reg, nom_out_reg, jit_out_reg, jit_out_next;

    logic [WIDE_W-1:0]    grow_prod, init_wide;
    logic [RATIO_W-1:0]   ratio_c;
    logic [RM_W:0]        rm_full;
    logic [RUN_W-1:0]     run_int;
    logic [SUM_W-1:0]     base, jit_ext, rounded;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            initial_reg <= INITIAL_RESET;
            maximum_reg <= MAXIMUM_RESET;
            growth_reg  <= GROWTH_RESET;
            spread_reg  <= SPREAD_RESET;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_INITIAL: initial_reg <= cfg_wdata;
                REG_MAXIMUM: maximum_reg <= cfg_wdata;
                REG_GROWTH:  growth_reg  <= cfg_wdata[GROWTH_W-1:0];
                REG_SPREAD:  spread_reg  <= cfg_wdata[RATIO_W-1:0];
                default: ;
            endcase
        end
    end

    // Counter and running delay
    always_comb begin
        attempt_next = (&attempt_reg) ? attempt_reg : attempt_reg + ATTEMPT_W'(1);
        grow_prod    = run_reg * growth_reg;
        init_wide    = WIDE_W'(initial_reg) << FRAC_BITS;
        if (attempt_reg == '0) begin
            run_next = sat_run(init_wide);
        end else begin
            run_next = sat_run(grow_prod >> GROWTH_FRAC);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attempt_reg <= '0;
            run_reg     <= '0;
        end else if (cmd.clear) begin
            attempt_reg <= '0;
            run_reg     <= '0;
        end else if (cmd.grow) begin
            attempt_reg <= attempt_next;
            run_reg     <= run_next;
        end
    end

    // Jitter chain
    always_comb begin
        mag_next     = sample[SAMPLE_W-1] ? SAMPLE_W'(0) - sample : sample;
        ratio_c      = spread_reg[RATIO_W-1] ? RATIO_ONE : spread_reg;
        rm_full      = ratio_c * mag_reg;
        run_int      = run_reg >> FRAC_BITS;
        nominal_next = (run_int < RUN_W'(maximum_reg)) ? run_int[DELAY_W-1:0] : maximum_reg;
        jit_next     = nominal_reg * rm_reg;
        base         = SUM_W'(nominal_reg) << JIT_FRAC;
        jit_ext      = SUM_W'(jit_reg);
        if (neg_reg) begin
            sum_next = (jit_ext > base) ? '0 : base - jit_ext;
        end else begin
            sum_next = base + jit_ext;
        end
        rounded      = (sum_reg + (SUM_W'(1) << (JIT_FRAC - 1))) >> JIT_FRAC;
        jit_out_next = (rounded > SUM_W'(maximum_reg)) ? maximum_reg
                                                       : rounded[DELAY_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            neg_reg <= sample[SAMPLE_W-1];
            mag_reg <= mag_next;
        end
        if (cmd.grow) begin
            rm_reg <= rm_full[RM_W-1:0];
        end
        if (cmd.nom) begin
            nominal_reg <= nominal_next;
        end
        if (cmd.jit) begin
            jit_reg <= jit_next;
        end
        if (cmd.sum) begin
            sum_reg <= sum_next;
        end
        if (cmd.load_out) begin
            att_out_reg <= attempt_reg;
            nom_out_reg <= nominal_reg;
            jit_out_reg <= jit_out_next;
        end
    end

    assign result = {jit_out_reg, nom_out_reg, att_out_reg};

endmodule

@@ hw/rtl/ebj_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebj_ctrl: sequencer of the backoff delay generator
// Accepts one beat at a time, steps the datapath through its chain and
// owns the result valid flag.
// ----------------------------------------------------------------------------
module ebj_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic             s_tuser,
    output logic             s_tready,
    output logic             m_tvalid,
    input  logic             m_tready,
    output ebj_pkg::dp_cmd_t cmd
);
    import ebj_pkg::*;

    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid && s_tuser == KIND_NEXT) begin
                    state_next = ST_GROW;
                end
            end
            ST_GROW: state_next = ST_NOM;
            ST_NOM:  state_next = ST_JIT;
            ST_JIT:  state_next = ST_SUM;
            ST_SUM:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == KIND_RESET) begin
                        cmd.clear = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                    end
                end
            end
            ST_GROW: cmd.grow = 1'b1;
            ST_NOM:  cmd.nom  = 1'b1;
            ST_JIT:  cmd.jit  = 1'b1;
            ST_SUM:  cmd.sum  = 1'b1;
            ST_OUT:  cmd.load_out = !m_valid_reg || m_tready;
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_tready))
        else $error("result register overwritten while held");

    // A next beat starts the chain
    a_next_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_NEXT) |=> state_reg == ST_GROW)
        else $error("next beat did not start the chain");

    // A reset beat starts no chain
    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser == KIND_RESET) |=> state_reg == ST_IDLE)
        else $error("reset beat left idle");

    // Valid rises only from a load in the final step
    a_valid_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result valid without a finished chain");

endmodule
